FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checks, clocked on clk, masked while rst_n is low.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/wve_pkg.sv
`timescale 1ns / 1ps
package wve_pkg;
  localparam int WAVE_SIZE_DEF = 1024;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam int CW = 17;             // envelope counts never exceed 2 * 65535
  localparam int DIV_STEPS = 33;      // bits of the dividend magnitude
  localparam logic [6:0] FULL_MIX = 7'h7f;
  localparam logic [CW-1:0] SUSTAIN_TICKS = CW'(100);

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_NOTE    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_WRITE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_ATTACK  = 2'd0,
    ST_DECAY   = 2'd1,
    ST_SUSTAIN = 2'd2,
    ST_RELEASE = 2'd3
  } env_stage_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_MIX      = 3'd0,
    REG_ATK_SOFT = 3'd1,
    REG_ATK_HARD = 3'd2,
    REG_REL_SOFT = 3'd3,
    REG_REL_HARD = 3'd4,
    REG_VOLUME   = 3'd5,
    REG_SUSTAIN  = 3'd6
  } reg_idx_t;
endpackage

FILE: sv/wve_in_if.sv
`timescale 1ns / 1ps
interface wve_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] acc_in;
  logic [6:0]         velocity;
  logic [31:0]        phase_step;
  logic               table_sel;
  logic [9:0]         table_index;
  logic signed [15:0] table_value;

  modport source (output valid, mode, acc_in, velocity, phase_step, table_sel,
                  table_index, table_value, input ready);
  modport sink (input valid, mode, acc_in, velocity, phase_step, table_sel,
                table_index, table_value, output ready);
endinterface

FILE: sv/wve_out_if.sv
`timescale 1ns / 1ps
interface wve_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mix_out;
  logic               active;

  modport source (output valid, mix_out, active, input ready);
  modport sink (input valid, mix_out, active, output ready);
endinterface

FILE: sv/wve_ram.sv
`timescale 1ns / 1ps
module wve_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/wavetable_voice_with_envelope.sv
`timescale 1ns / 1ps
// One wavetable voice with an ADSR envelope.
// in_ch carries commands: tick (mode 0), note start (1), release (2) and
// wave table write (3). Every accepted beat gives exactly one out_ch beat:
// mix_out is acc_in plus the scaled voice sample on a sounding tick, else
// acc_in unchanged; active is the voice state after the command.
// cfg_we/cfg_idx/cfg_data write the seven registers; write only while idle.
// Release, table write and silent tick go straight to the output register.
// A sounding tick makes two sequential reads of the single wave RAM read
// port; a tick that changes stage with a divide, and a note start, run
// the bit-serial divider (one quotient bit a cycle, 33 bits).
// One command is in flight at a time; in_ch.ready is high while idle. The
// output register holds a beat until out_ch.ready; the next command may be
// accepted meanwhile, and its result waits until the register is free.
// Reset (synchronous, rst_n low) clears configuration, control and voice state; wave
// table contents are not cleared and must be written before use.
module wavetable_voice_with_envelope #(
  parameter int WAVE_SIZE = wve_pkg::WAVE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wve_in_if.sink                     in_ch,
  wve_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [wve_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [wve_pkg::CFG_DW-1:0] cfg_data
);
  import wve_pkg::*;

  localparam int AW = $clog2(WAVE_SIZE);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_RD0   = 10'b00_0000_0010,
    S_RD1   = 10'b00_0000_0100,
    S_MIX   = 10'b00_0000_1000,
    S_ENV   = 10'b00_0001_0000,
    S_DIV   = 10'b00_0010_0000,
    S_SCALE = 10'b00_0100_0000,
    S_ADD   = 10'b00_1000_0000,
    S_NOTE  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r;

  // configuration
  logic [6:0]  mix_r, vol_r, sus_frac_r;
  logic [15:0] atk_soft_r, atk_hard_r, rel_soft_r, rel_hard_r;

  // voice state
  logic [31:0]        phase_r, step_r;
  env_stage_t         stage_r;
  logic               rel_flag_r, voice_on_r;
  logic [CW-1:0]      count_r, decay_cnt_r, rel_cnt_r;
  logic [31:0]        delta_r;
  logic signed [31:0] level_r, sus_tgt_r;

  // per-command working registers
  logic signed [15:0] acc_r, res_r, s0_r;
  logic [6:0]         vel_r;
  logic signed [16:0] sample_r;
  logic signed [32:0] prod_r;

  // bit-serial divider
  logic [32:0]   div_q_r;
  logic [CW-1:0] div_rem_r, div_den_r;
  logic          div_neg_r, div_tick_r;
  logic [5:0]    div_cnt_r;

  logic               out_valid_r, out_act_r;
  logic signed [15:0] out_mix_r;

  // wave RAM
  logic                  ram_we;
  logic [AW:0]           ram_waddr, ram_raddr;
  logic [15:0]           ram_rdata;
  logic [31:0]           tidx_ext;
  logic [AW-1:0]         rd_idx;

  assign tidx_ext  = 32'(in_ch.table_index);
  assign rd_idx    = phase_r[31 -: AW];
  assign ram_waddr = {in_ch.table_sel, tidx_ext[AW-1:0]};
  assign ram_we    = (state_r == S_IDLE) && in_ch.valid && (in_ch.mode == MODE_WRITE)
                     && (tidx_ext < 32'(WAVE_SIZE));
  assign ram_raddr = {(state_r == S_RD1), rd_idx};

  wve_ram #(.W(16), .DEPTH(2 * WAVE_SIZE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.table_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // crossfade of the two table samples
  logic signed [15:0] s1;
  logic signed [23:0] xf_sum;
  logic signed [16:0] xf_sample;
  always_comb begin
    s1     = ram_rdata;
    xf_sum = 24'(s0_r) * 24'($signed({1'b0, FULL_MIX - mix_r}))
           + 24'(s1) * 24'($signed({1'b0, mix_r}));
    if (mix_r == 7'd0) begin
      xf_sample = 17'(s0_r);
    end else if (mix_r >= FULL_MIX) begin
      xf_sample = 17'(s1);
    end else begin
      xf_sample = 17'(xf_sum >>> 7);
    end
  end

  // note start arithmetic
  logic [23:0] atk_sum, rls_sum;
  logic [15:0] atk, rls;
  logic [29:0] sus_prod;
  always_comb begin
    atk_sum  = 24'(atk_soft_r) * 24'(FULL_MIX - vel_r) + 24'(atk_hard_r) * 24'(vel_r);
    rls_sum  = 24'(rel_soft_r) * 24'(FULL_MIX - vel_r) + 24'(rel_hard_r) * 24'(vel_r);
    atk      = atk_sum[22:7];
    rls      = rls_sum[22:7];
    sus_prod = 30'({vol_r, 16'b0}) * 30'(sus_frac_r);
  end

  // envelope divide operands
  logic signed [32:0] dnum_decay, dnum_rel;
  assign dnum_decay = 33'(sus_tgt_r) - 33'(level_r);
  assign dnum_rel   = -33'(level_r);

  // one restoring step a cycle
  logic [CW:0]   rem_sh;
  logic          qbit;
  logic [32:0]   q_fin;
  logic [31:0]   q_signed;
  always_comb begin
    rem_sh   = {div_rem_r, div_q_r[32]};
    qbit     = rem_sh >= {1'b0, div_den_r};
    q_fin    = {div_q_r[31:0], qbit};
    q_signed = div_neg_r ? 32'(-q_fin) : q_fin[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r <= '0; vol_r <= '0; sus_frac_r <= '0;
      atk_soft_r <= '0; atk_hard_r <= '0; rel_soft_r <= '0; rel_hard_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MIX:      mix_r      <= cfg_data[6:0];
        REG_ATK_SOFT: atk_soft_r <= cfg_data;
        REG_ATK_HARD: atk_hard_r <= cfg_data;
        REG_REL_SOFT: rel_soft_r <= cfg_data;
        REG_REL_HARD: rel_hard_r <= cfg_data;
        REG_VOLUME:   vol_r      <= cfg_data[6:0];
        REG_SUSTAIN:  sus_frac_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  task automatic start_div(input logic signed [32:0] num, input logic [CW-1:0] den,
                           input logic from_tick);
    div_neg_r  <= num[32];
    div_q_r    <= num[32] ? 33'(-num) : num;
    div_den_r  <= (den == '0) ? CW'(1) : den;
    div_rem_r  <= '0;
    div_cnt_r  <= '0;
    div_tick_r <= from_tick;
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r <= '0; step_r <= '0; stage_r <= ST_ATTACK;
      rel_flag_r <= 1'b0; voice_on_r <= 1'b0;
      count_r <= '0; delta_r <= '0; level_r <= '0;
      decay_cnt_r <= '0; sus_tgt_r <= '0; rel_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      if ((state_r == S_OUT) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            acc_r <= in_ch.acc_in;
            res_r <= in_ch.acc_in;
            vel_r <= in_ch.velocity;
            case (in_ch.mode)
              MODE_TICK: begin
                if (voice_on_r) begin
                  phase_r <= phase_r + step_r;
                  state_r <= S_RD0;
                end else begin
                  state_r <= S_OUT;
                end
              end
              MODE_NOTE: begin
                step_r  <= in_ch.phase_step;
                state_r <= S_NOTE;
              end
              MODE_RELEASE: begin
                rel_flag_r <= 1'b1;
                state_r    <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          s0_r    <= ram_rdata;
          state_r <= S_MIX;
        end
        S_MIX: begin
          sample_r <= xf_sample;
          state_r  <= S_ENV;
        end
        S_ENV: begin
          if (count_r != '0) begin
            count_r <= count_r - CW'(1);
            level_r <= level_r + $signed(delta_r);
            state_r <= S_SCALE;
          end else begin
            case (stage_r)
              ST_ATTACK: begin
                stage_r <= ST_DECAY;
                count_r <= decay_cnt_r;
                start_div(dnum_decay, decay_cnt_r, 1'b1);
                state_r <= S_DIV;
              end
              ST_DECAY: begin
                stage_r <= ST_SUSTAIN;
                count_r <= SUSTAIN_TICKS;
                delta_r <= '0;
                state_r <= S_SCALE;
              end
              ST_SUSTAIN: begin
                if (rel_flag_r) begin
                  stage_r <= ST_RELEASE;
                  count_r <= rel_cnt_r;
                  start_div(dnum_rel, rel_cnt_r, 1'b1);
                  state_r <= S_DIV;
                end else begin
                  count_r <= SUSTAIN_TICKS;
                  state_r <= S_SCALE;
                end
              end
              default: begin
                // release finished: voice falls silent, tick adds nothing
                voice_on_r <= 1'b0;
                state_r    <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          div_rem_r <= qbit ? CW'(rem_sh - {1'b0, div_den_r}) : rem_sh[CW-1:0];
          div_q_r   <= q_fin;
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'(DIV_STEPS - 1)) begin
            delta_r <= q_signed;
            state_r <= div_tick_r ? S_SCALE : S_OUT;
          end
        end
        S_SCALE: begin
          prod_r  <= sample_r * $signed(level_r[31:16]);
          state_r <= S_ADD;
        end
        S_ADD: begin
          res_r   <= acc_r + prod_r[30:15];
          state_r <= S_OUT;
        end
        S_NOTE: begin
          stage_r     <= ST_ATTACK;
          level_r     <= '0;
          rel_flag_r  <= 1'b0;
          voice_on_r  <= 1'b1;
          count_r     <= CW'(atk);
          decay_cnt_r <= {atk, 1'b0};
          sus_tgt_r   <= 32'(sus_prod);
          rel_cnt_r   <= CW'(rls);
          start_div(33'({vol_r, 23'b0}), CW'(atk), 1'b0);
          state_r     <= S_DIV;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_mix_r   <= res_r;
            out_act_r   <= voice_on_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.mix_out = out_mix_r;
  assign out_ch.active  = out_act_r;

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
               "block still ready after taking a command")
  `ASSERT_SAME(a_div_bound, state_r == S_DIV, div_cnt_r < 6'(DIV_STEPS),
               "divider ran past its last step")
  `ASSERT_NEXT(a_release_end, (state_r == S_ENV) && (count_r == '0)
               && (stage_r == ST_RELEASE), !voice_on_r && (state_r == S_OUT),
               "voice still on after release ended")
endmodule
